// ===== hw/rtl/mrgf_pkg.sv =====
`default_nettype none
package mrgf_pkg;

  typedef enum logic [1:0] {
    RegWheelRadius  = 2'd0,
    RegGripGain     = 2'd1,
    RegForceLimit   = 2'd2,
    RegGroundHeight = 2'd3
  } cfg_reg_t;

  localparam int CfgAddrW = 4;

  typedef logic [47:0] vec3_t;
  typedef logic [63:0] quat_t;
  typedef logic signed [16:0] force_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mrgf_channels.sv =====
`default_nettype none
interface mrgf_in_if;
  logic                 valid;
  logic                 ready;
  mrgf_pkg::vec3_t      base_position;
  mrgf_pkg::quat_t      base_orientation;
  mrgf_pkg::vec3_t      base_velocity;
  mrgf_pkg::vec3_t      base_spin;
  mrgf_pkg::vec3_t      wheel_position;
  logic signed [15:0]   wheel_rate;
  logic [1:0]           wheel_select;

  modport source (output valid, base_position, base_orientation, base_velocity,
                  base_spin, wheel_position, wheel_rate, wheel_select,
                  input ready);
  modport sink (input valid, base_position, base_orientation, base_velocity,
                base_spin, wheel_position, wheel_rate, wheel_select,
                output ready);
endinterface

interface mrgf_out_if;
  logic                 valid;
  logic                 ready;
  mrgf_pkg::force_t     force_x;
  mrgf_pkg::force_t     force_y;
  mrgf_pkg::force_t     force_z;
  logic                 on_ground;

  modport source (output valid, force_x, force_y, force_z, on_ground, input ready);
  modport sink (input valid, force_x, force_y, force_z, on_ground, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mecanum_roller_grip_force_core.sv =====
`default_nettype none
// Channel  | Direction | Handshake        | Beat contents
// in_bus   | in        | valid/ready      | pose, velocities, wheel centre, rate, select
// out_bus  | out       | valid/ready      | force x/y/z, on_ground
// cfg_*    | in        | APB, pready = 1  | radius, gain, force_limit,
//          |           |                  | ground_height at 0x0, 0x4, 0x8, 0xC
//
// One beat is accepted per cycle while the pipeline advances; each result passes
// through the ten register stages of the multiply and round chain.
// The whole pipeline advances together whenever the output register is empty
// or is being taken, so a stall freezes every stage and holds its valid bit.
// rst_n is synchronous, clears the valid bits and loads the configuration defaults.
module mecanum_roller_grip_force_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mrgf_in_if.sink                              in_bus,
  mrgf_out_if.source                           out_bus,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [mrgf_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import mrgf_pkg::*;

  localparam int NStg = 10;
  localparam logic signed [34:0] OneQ28 = 35'sd268435456;
  localparam logic signed [14:0] GripQ14 = 15'sd11585;

  // Configuration registers.
  logic [11:0]        radius_r;
  logic [15:0]        gain_r;
  logic [15:0]        limit_r;
  logic signed [15:0] ground_r;
  cfg_reg_t           cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 12'd200;
      gain_r   <= 16'd2000;
      limit_r  <= 16'd13312;
      ground_r <= 16'sd13;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_sel)
        RegWheelRadius:  radius_r <= cfg_pwdata[11:0];
        RegGripGain:     gain_r   <= cfg_pwdata[15:0];
        RegForceLimit:   limit_r  <= cfg_pwdata[15:0];
        RegGroundHeight: ground_r <= $signed(cfg_pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegWheelRadius:  cfg_prdata = {20'd0, radius_r};
      RegGripGain:     cfg_prdata = {16'd0, gain_r};
      RegForceLimit:   cfg_prdata = {16'd0, limit_r};
      RegGroundHeight: cfg_prdata = {{16{ground_r[15]}}, ground_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline control.
  logic [NStg-1:0] v_r;
  logic            adv;

  assign adv          = !v_r[NStg-1] || out_bus.ready;
  assign in_bus.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NStg-2:0], in_bus.valid};
    end
  end

  logic signed [12:0] radius_s;
  assign radius_s = $signed({1'b0, radius_r});

  // Stage 1: quaternion products, lever arm cross products, rate times radius.
  logic signed [15:0] qw, qx, qy, qz, pwz;
  logic signed [15:0] vb [3];
  logic signed [15:0] wb [3];
  logic signed [16:0] dd [3];

  always_comb begin
    qw  = $signed(in_bus.base_orientation[15:0]);
    qx  = $signed(in_bus.base_orientation[31:16]);
    qy  = $signed(in_bus.base_orientation[47:32]);
    qz  = $signed(in_bus.base_orientation[63:48]);
    pwz = $signed(in_bus.wheel_position[47:32]);
    for (int i = 0; i < 3; i++) begin
      vb[i] = $signed(in_bus.base_velocity[16*i +: 16]);
      wb[i] = $signed(in_bus.base_spin[16*i +: 16]);
      dd[i] = 17'($signed(in_bus.wheel_position[16*i +: 16]))
            - 17'($signed(in_bus.base_position[16*i +: 16]));
    end
  end

  logic signed [31:0] s1_xx_r, s1_yy_r, s1_zz_r, s1_xy_r, s1_wz_r, s1_xz_r, s1_wy_r;
  logic signed [31:0] s1_yz_r, s1_wx_r;
  logic signed [32:0] s1_c_r [6];
  logic signed [15:0] s1_vb_r [3];
  logic signed [28:0] s1_rr_r;
  logic signed [15:0] s1_pwz_r;
  logic [1:0]         s1_sel_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xx_r   <= qx * qx;
      s1_yy_r   <= qy * qy;
      s1_zz_r   <= qz * qz;
      s1_xy_r   <= qx * qy;
      s1_wz_r   <= qw * qz;
      s1_xz_r   <= qx * qz;
      s1_wy_r   <= qw * qy;
      s1_yz_r   <= qy * qz;
      s1_wx_r   <= qw * qx;
      s1_c_r[0] <= wb[1] * dd[2];
      s1_c_r[1] <= wb[2] * dd[1];
      s1_c_r[2] <= wb[2] * dd[0];
      s1_c_r[3] <= wb[0] * dd[2];
      s1_c_r[4] <= wb[0] * dd[1];
      s1_c_r[5] <= wb[1] * dd[0];
      s1_vb_r   <= vb;
      s1_rr_r   <= in_bus.wheel_rate * radius_s;
      s1_pwz_r  <= pwz;
      s1_sel_r  <= in_bus.wheel_select;
    end
  end

  // Stage 2: rotation matrix rounded to Q14, contact velocity at scale 2^16.
  logic signed [34:0] rf [9];
  logic signed [20:0] rq_nxt [9];
  logic signed [34:0] vc_nxt [3];

  always_comb begin
    rf[0] = OneQ28 - ((35'(s1_yy_r) + 35'(s1_zz_r)) <<< 1);
    rf[1] = (35'(s1_xy_r) - 35'(s1_wz_r)) <<< 1;
    rf[2] = (35'(s1_xz_r) + 35'(s1_wy_r)) <<< 1;
    rf[3] = (35'(s1_xy_r) + 35'(s1_wz_r)) <<< 1;
    rf[4] = OneQ28 - ((35'(s1_xx_r) + 35'(s1_zz_r)) <<< 1);
    rf[5] = (35'(s1_yz_r) - 35'(s1_wx_r)) <<< 1;
    rf[6] = (35'(s1_xz_r) - 35'(s1_wy_r)) <<< 1;
    rf[7] = (35'(s1_yz_r) + 35'(s1_wx_r)) <<< 1;
    rf[8] = OneQ28 - ((35'(s1_xx_r) + 35'(s1_yy_r)) <<< 1);
    for (int i = 0; i < 9; i++) begin
      rq_nxt[i] = 21'((rf[i] + 35'sd8192) >>> 14);
    end
    for (int i = 0; i < 3; i++) begin
      vc_nxt[i] = (35'(s1_vb_r[i]) <<< 8) + 35'(s1_c_r[2*i]) - 35'(s1_c_r[2*i+1]);
    end
  end

  logic signed [20:0] s2_rq_r [9];
  logic signed [34:0] s2_vc_r [3];
  logic signed [28:0] s2_rr_r;
  logic signed [15:0] s2_pwz_r;
  logic [1:0]         s2_sel_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rq_r  <= rq_nxt;
      s2_vc_r  <= vc_nxt;
      s2_rr_r  <= s1_rr_r;
      s2_pwz_r <= s1_pwz_r;
      s2_sel_r <= s1_sel_r;
    end
  end

  // Stage 3: grip direction in world frame, surface speed and height products.
  logic               neg_y;
  logic signed [21:0] gsum [3];
  logic signed [36:0] gprod [3];
  logic signed [23:0] u_nxt [3];

  always_comb begin
    neg_y = (s2_sel_r == 2'd0) || (s2_sel_r == 2'd3);
    for (int i = 0; i < 3; i++) begin
      gsum[i]  = neg_y ? 22'(s2_rq_r[3*i]) - 22'(s2_rq_r[3*i+1])
                       : 22'(s2_rq_r[3*i]) + 22'(s2_rq_r[3*i+1]);
      gprod[i] = gsum[i] * GripQ14;
      u_nxt[i] = 24'((gprod[i] + 37'sd8192) >>> 14);
    end
  end

  logic signed [23:0] s3_u_r [3];
  logic signed [49:0] s3_sp_r [3];
  logic signed [33:0] s3_hp_r;
  logic signed [34:0] s3_vc_r [3];
  logic signed [15:0] s3_pwz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_u_r <= u_nxt;
      for (int i = 0; i < 3; i++) begin
        s3_sp_r[i] <= s2_rr_r * s2_rq_r[3*i];
      end
      s3_hp_r  <= radius_s * s2_rq_r[8];
      s3_vc_r  <= s2_vc_r;
      s3_pwz_r <= s2_pwz_r;
    end
  end

  // Stage 4: slip per axis and ground test.
  logic signed [35:0] slip_nxt [3];
  logic signed [17:0] hz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      slip_nxt[i] = 36'(s3_vc_r[i]) - 36'((s3_sp_r[i] + 50'sd131072) >>> 18);
    end
    hz = 18'(s3_pwz_r) - 18'((s3_hp_r + 34'sd131072) >>> 18);
  end

  logic signed [35:0] s4_slip_r [3];
  logic signed [23:0] s4_u_r [3];
  logic               s4_off_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_slip_r <= slip_nxt;
      s4_u_r    <= s3_u_r;
      s4_off_r  <= hz > 18'(ground_r);
    end
  end

  // Stage 5: slip times direction.
  logic signed [59:0] s5_m_r [3];
  logic signed [23:0] s5_u_r [3];
  logic               s5_off_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_m_r[i] <= s4_slip_r[i] * s4_u_r[i];
      end
      s5_u_r   <= s4_u_r;
      s5_off_r <= s4_off_r;
    end
  end

  // Stage 6: projection. Beyond 2^24 any nonzero gain already exceeds the
  // largest force limit, so saturating there gives the same clamped force.
  logic signed [61:0] dot;
  logic signed [61:0] sproj;
  logic signed [25:0] s_nxt;

  always_comb begin
    dot   = 62'(s5_m_r[0]) + 62'(s5_m_r[1]) + 62'(s5_m_r[2]);
    sproj = (dot + 62'sd8192) >>> 14;
    if (sproj > 62'sd16777216) begin
      s_nxt = 26'sd16777216;
    end else if (sproj < -62'sd16777216) begin
      s_nxt = -26'sd16777216;
    end else begin
      s_nxt = 26'(sproj);
    end
  end

  logic signed [25:0] s6_s_r;
  logic signed [23:0] s6_u_r [3];
  logic               s6_off_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_s_r   <= s_nxt;
      s6_u_r   <= s5_u_r;
      s6_off_r <= s5_off_r;
    end
  end

  // Stage 7: gain multiply.
  logic signed [42:0] s7_gp_r;
  logic signed [23:0] s7_u_r [3];
  logic               s7_off_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_gp_r  <= $signed({1'b0, gain_r}) * s6_s_r;
      s7_u_r   <= s6_u_r;
      s7_off_r <= s6_off_r;
    end
  end

  // Stage 8: force magnitude clamped to the limit.
  logic signed [42:0] fr;
  logic signed [42:0] lim;
  logic signed [16:0] fmag_nxt;

  always_comb begin
    fr  = (s7_gp_r + 43'sd128) >>> 8;
    lim = 43'($signed({1'b0, limit_r}));
    if (fr > lim) begin
      fmag_nxt = 17'(lim);
    end else if (fr < -lim) begin
      fmag_nxt = 17'(-lim);
    end else begin
      fmag_nxt = 17'(fr);
    end
  end

  logic signed [16:0] s8_fmag_r;
  logic signed [23:0] s8_u_r [3];
  logic               s8_off_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_fmag_r <= fmag_nxt;
      s8_u_r    <= s7_u_r;
      s8_off_r  <= s7_off_r;
    end
  end

  // Stage 9: force along the grip direction.
  logic signed [40:0] s9_fu_r [3];
  logic               s9_off_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s9_fu_r[i] <= s8_fmag_r * s8_u_r[i];
      end
      s9_off_r <= s8_off_r;
    end
  end

  // Stage 10: round, negate, saturate (or zero when off ground) into the output register.
  logic signed [40:0] fneg [3];
  force_t             f_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fneg[i] = -((s9_fu_r[i] + 41'sd8192) >>> 14);
      if (s9_off_r) begin
        f_nxt[i] = '0;
      end else if (fneg[i] > 41'sd65535) begin
        f_nxt[i] = 17'sd65535;
      end else if (fneg[i] < -41'sd65535) begin
        f_nxt[i] = -17'sd65535;
      end else begin
        f_nxt[i] = 17'(fneg[i]);
      end
    end
  end

  force_t s10_f_r [3];
  logic   s10_on_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_f_r  <= f_nxt;
      s10_on_r <= !s9_off_r;
    end
  end

  assign out_bus.valid     = v_r[NStg-1];
  assign out_bus.force_x   = s10_f_r[0];
  assign out_bus.force_y   = s10_f_r[1];
  assign out_bus.force_z   = s10_f_r[2];
  assign out_bus.on_ground = s10_on_r;

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.on_ground |->
      out_bus.force_x == '0 && out_bus.force_y == '0 && out_bus.force_z == '0)
    else $error("off-ground result carries force");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.ready |-> !in_bus.ready)
    else $error("input taken while pipeline is stalled");

  a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> v_r[0])
    else $error("accepted beat lost at pipeline entry");

endmodule
`default_nettype wire
